// ===== rtl/mrer_pkg.sv =====
// ----------------------------------------------------------------------------
// mrer_pkg: shared types and constants for the row echelon reduction block
// Matrix geometry, configuration register indexes and the request/response
// bundles that pass between the sequencer and the elimination unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrer_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int IDX_W    = 3;            // row or column index
  localparam int CNT_W    = 4;            // loop counter, can hold the bound
  localparam int ADDR_W   = 6;            // store address {row, col}
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int DIV_STEPS = 64;          // quotient bits of the divider

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS      = 2'd0;
  localparam logic [1:0] REG_COLS      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;        // pivot value of the reference row
    logic signed [31:0] big_a;    // pivot value of the row being reduced
    logic signed [31:0] ml;       // reference row entry
    logic signed [31:0] mr;       // entry being reduced
  } elim_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] value;    // saturated mr - big_a*ml/a
  } elim_rsp_t;

endpackage

// ===== rtl/mrer_div.sv =====
// ----------------------------------------------------------------------------
// mrer_div: unsigned restoring divider, 64-bit dividend by 32-bit divisor
// Produces one quotient bit per cycle; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrer_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] dvd;
  logic [31:0] dvs;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, dvd[63]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'(mrer_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[62:0], 1'b0};
      rem      <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quotient <= {quotient[62:0], ge};
    end
  end

endmodule

// ===== rtl/mrer_elim.sv =====
// ----------------------------------------------------------------------------
// mrer_elim: shared elimination arithmetic
// Computes sat32(mr - trunc(big_a * ml / a)) with a registered multiply and
// the bit-serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrer_elim (
  input  logic                clk,
  input  logic                rst,
  input  mrer_pkg::elim_req_t req,
  output mrer_pkg::elim_rsp_t rsp
);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_DIV  = 4'b0100,
    E_FIN  = 4'b1000
  } estate_t;

  estate_t            state;
  logic signed [63:0] prod;
  logic signed [31:0] a_r;
  logic signed [31:0] mr_r;
  logic               neg;
  logic [63:0]        prod_mag;
  logic [31:0]        a_mag;
  logic               div_done;
  logic [63:0]        quot;
  logic signed [64:0] q_s;
  logic signed [65:0] diff;
  logic signed [31:0] sat;
  logic               done_r;
  logic signed [31:0] value_r;

  assign prod_mag = prod[63] ? 64'(-prod) : 64'(prod);
  assign a_mag    = a_r[31] ? 32'(-a_r) : 32'(a_r);

  mrer_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == E_MUL),
    .dividend (prod_mag),
    .divisor  (a_mag),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    q_s  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    diff = 66'(mr_r) - 66'(q_s);
    if (diff > 66'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (diff < -66'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state)
        E_IDLE: if (req.start) state <= E_MUL;
        E_MUL:  state <= E_DIV;
        E_DIV:  if (div_done) state <= E_FIN;
        E_FIN: begin
          done_r <= 1'b1;
          state  <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && req.start) begin
      prod <= 64'(req.big_a) * 64'(req.ml);
      a_r  <= req.a;
      mr_r <= req.mr;
      neg  <= req.big_a[31] ^ req.ml[31] ^ req.a[31];
    end
    if (state == E_FIN) begin
      value_r <= sat;
    end
  end

  assign rsp = '{busy: (state != E_IDLE), done: done_r, value: value_r};

endmodule

// ===== rtl/matrix_row_echelon_reduce.sv =====
// ----------------------------------------------------------------------------
// matrix_row_echelon_reduce: Q16.16 row echelon reduction of up to 8x8
// Elements load while the block is idle; the last element starts a reduction
// whose length depends on the data: the pivot search reads and then checks
// each entry examined, and each eliminated entry is read from both rows and
// then waits on the shared multiply/divide unit.
// Output then streams row-major; each read waits for a free output register.
// Synchronous active-high reset clears control state; the store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_row_echelon_reduce (
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata = element_value[31:0]; tlast = last_element.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  // Output stream: tdata = result_value[31:0], result_row[34:32],
  // result_col[37:35], zero fill [39:38]; tlast = last_result.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = mrer_pkg::IDX_W;
  localparam int CW = mrer_pkg::CNT_W;

  // One-hot sequencer. Pivot search, then the j/l/r/k elimination loops,
  // then the output sweep.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FRD   = 11'b00000000010,
    S_FCHK  = 11'b00000000100,
    S_LSEL  = 11'b00000001000,
    S_RSEL  = 11'b00000010000,
    S_KCHK  = 11'b00000100000,
    S_KRDL  = 11'b00001000000,
    S_KRDR  = 11'b00010000000,
    S_KWAIT = 11'b00100000000,
    S_ORD   = 11'b01000000000,
    S_OLD   = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration registers and their clamped values.
  logic [3:0]  rows_in_use;
  logic [3:0]  cols_in_use;
  logic [15:0] zero_threshold;
  logic [CW-1:0] nr;
  logic [CW-1:0] nc;

  always_comb begin
    if (rows_in_use == 4'd0) nr = CW'(1);
    else if (rows_in_use > 4'(mrer_pkg::MAX_ROWS)) nr = CW'(mrer_pkg::MAX_ROWS);
    else nr = rows_in_use;
    if (cols_in_use == 4'd0) nc = CW'(1);
    else if (cols_in_use > 4'(mrer_pkg::MAX_COLS)) nc = CW'(mrer_pkg::MAX_COLS);
    else nc = cols_in_use;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= 4'(mrer_pkg::MAX_ROWS);
      cols_in_use    <= 4'(mrer_pkg::MAX_COLS);
      zero_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrer_pkg::REG_ROWS:      rows_in_use    <= cfg_data[3:0];
        mrer_pkg::REG_COLS:      cols_in_use    <= cfg_data[3:0];
        mrer_pkg::REG_THRESHOLD: zero_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load position and its row/column split. The position can reach the
  // full store size, so it carries one bit more than the store address.
  // The quotient is below eight, so three compare-and-subtract steps
  // resolve it.
  logic [6:0]    load_pos;
  logic [6:0]    total;
  logic [6:0]    rem0, rem1, rem2, rem3, dv;
  logic [IW-1:0] load_row;
  logic [IW-1:0] load_col;
  logic          load_en;

  always_comb begin
    total       = 7'(nr) * 7'(nc);
    dv          = 7'(nc);
    rem0        = load_pos;
    load_row[2] = rem0 >= (dv << 2);
    rem1        = load_row[2] ? rem0 - (dv << 2) : rem0;
    load_row[1] = rem1 >= (dv << 1);
    rem2        = load_row[1] ? rem1 - (dv << 1) : rem1;
    load_row[0] = rem2 >= dv;
    rem3        = load_row[0] ? rem2 - dv : rem2;
    load_col    = rem3[IW-1:0];
  end

  assign s_tready = (state == S_IDLE);
  assign load_en  = s_tvalid && s_tready && (load_pos < total);

  // Loop counters.
  logic [CW-1:0] r;
  logic [CW-1:0] c;
  logic [CW-1:0] l;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic          searching;

  // Pivot bookkeeping, one entry per row.
  logic signed [31:0] pv    [mrer_pkg::MAX_ROWS];
  logic [IW-1:0]      pcol  [mrer_pkg::MAX_ROWS];
  logic [mrer_pkg::MAX_ROWS-1:0] pf;
  logic [IW-1:0]      pidx;
  logic               pmatch;
  // Pivot value of the row being reduced, held from the start of its pass
  // so that a pivot move partway through does not change the multiplier.
  logic signed [31:0] big_a;

  assign pidx   = (state == S_LSEL) ? l[IW-1:0] : r[IW-1:0];
  assign pmatch = pf[pidx] && (pcol[pidx] == j[IW-1:0]);

  // Element store: one write and one registered read port.
  logic signed [31:0] mem [mrer_pkg::DEPTH];
  logic [mrer_pkg::ADDR_W-1:0] wr_addr;
  logic [mrer_pkg::ADDR_W-1:0] rd_addr;
  logic signed [31:0] wr_data;
  logic signed [31:0] rd_data;
  logic               wr_en;
  logic signed [31:0] ml;

  mrer_pkg::elim_req_t req;
  mrer_pkg::elim_rsp_t rsp;
  logic [31:0]         v_mag;

  assign v_mag = rsp.value[31] ? 32'(-rsp.value) : 32'(rsp.value);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {load_row, load_col};
    wr_data = s_tdata;
    if (state == S_IDLE) begin
      wr_en = load_en;
    end else if (state == S_RSEL && r != nr && r != l && pmatch) begin
      // The pivot entry of the reduced row is cleared outright.
      wr_en   = 1'b1;
      wr_addr = {r[IW-1:0], pcol[pidx]};
      wr_data = '0;
    end else if (state == S_KWAIT && rsp.done) begin
      wr_en   = 1'b1;
      wr_addr = {r[IW-1:0], k[IW-1:0]};
      wr_data = rsp.value;
    end
  end

  always_comb begin
    priority case (1'b1)
      state == S_KCHK: rd_addr = {l[IW-1:0], k[IW-1:0]};
      state == S_KRDL: rd_addr = {r[IW-1:0], k[IW-1:0]};
      default:         rd_addr = {r[IW-1:0], c[IW-1:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign req = '{start: (state == S_KRDR), a: pv[l[IW-1:0]], big_a: big_a,
                 ml: ml, mr: rd_data};

  mrer_elim u_elim (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      load_pos <= '0;
      m_tvalid <= 1'b0;
      pf       <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (load_en) load_pos <= load_pos + 7'd1;
            if (s_tlast) begin
              r     <= '0;
              c     <= '0;
              state <= S_FRD;
            end
          end
        end
        S_FRD: begin
          if (r == nr) begin
            j     <= '0;
            l     <= '0;
            state <= S_LSEL;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (rd_data != 32'sd0) begin
            pv[r[IW-1:0]]   <= rd_data;
            pcol[r[IW-1:0]] <= c[IW-1:0];
            pf[r[IW-1:0]]   <= 1'b1;
            r <= r + CW'(1);
            c <= '0;
          end else if (c + CW'(1) == nc) begin
            pf[r[IW-1:0]] <= 1'b0;
            r <= r + CW'(1);
            c <= '0;
          end else begin
            c <= c + CW'(1);
          end
          state <= S_FRD;
        end
        S_LSEL: begin
          if (j + CW'(1) >= nc) begin
            r     <= '0;
            c     <= '0;
            state <= S_ORD;
          end else if (l == nr) begin
            j <= j + CW'(1);
            l <= '0;
          end else if (pmatch) begin
            r     <= '0;
            state <= S_RSEL;
          end else begin
            l <= l + CW'(1);
          end
        end
        S_RSEL: begin
          if (r == nr) begin
            l     <= l + CW'(1);
            state <= S_LSEL;
          end else if (r != l && pmatch) begin
            searching <= 1'b1;
            big_a     <= pv[pidx];
            k         <= CW'(pcol[pidx]) + CW'(1);
            state     <= S_KCHK;
          end else begin
            r <= r + CW'(1);
          end
        end
        S_KCHK: begin
          if (k >= nc) begin
            if (searching) pf[r[IW-1:0]] <= 1'b0;
            r     <= r + CW'(1);
            state <= S_RSEL;
          end else begin
            state <= S_KRDL;
          end
        end
        S_KRDL: begin
          ml    <= rd_data;
          state <= S_KRDR;
        end
        S_KRDR: state <= S_KWAIT;
        S_KWAIT: begin
          if (rsp.done) begin
            if (searching && v_mag > {16'd0, zero_threshold}) begin
              pv[r[IW-1:0]]   <= rsp.value;
              pcol[r[IW-1:0]] <= k[IW-1:0];
              searching       <= 1'b0;
            end
            k     <= k + CW'(1);
            state <= S_KCHK;
          end
        end
        S_ORD: begin
          if (!m_tvalid || m_tready) state <= S_OLD;
        end
        S_OLD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {2'b00, c[IW-1:0], r[IW-1:0], rd_data};
          m_tlast  <= (r + CW'(1) == nr) && (c + CW'(1) == nc);
          if ((r + CW'(1) == nr) && (c + CW'(1) == nc)) begin
            load_pos <= '0;
            state    <= S_IDLE;
          end else begin
            if (c + CW'(1) == nc) begin
              c <= '0;
              r <= r + CW'(1);
            end else begin
              c <= c + CW'(1);
            end
            state <= S_ORD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Input is never taken while the arithmetic unit still works on an entry.
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !rsp.busy)
    else $error("input accepted while elimination unit busy");
  // Results of the arithmetic unit only arrive while the sequencer waits.
  assert property (@(posedge clk) disable iff (rst) rsp.done |-> state == S_KWAIT)
    else $error("elimination result arrived outside wait state");
  // The flagged final result sits in the last column in use.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[37:35] == 3'(nc - CW'(1))))
    else $error("final result not in last column");
`endif

endmodule

// ===== tb/sv/matrix_row_echelon_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_row_echelon_reduce_tb: self-checking bench for the echelon reducer
// Streams matrices of random and directed content through the block under
// several size and threshold settings, predicts every reduced element with
// an independent Q16.16 elimination model and checks the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_row_echelon_reduce_tb;

  localparam int WATCHDOG_LIMIT = 200000;

  // One pending input transfer, or a marker that asks for a register write
  // or a drain of every expected result before going on.
  typedef enum logic [1:0] {ACT_ELEM, ACT_CFG, ACT_DRAIN} act_kind_e;
  typedef struct packed {
    act_kind_e   kind;
    logic [31:0] value;
    logic        last;
    logic [1:0]  index;
    logic [15:0] cdata;
  } act_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } elem_out_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  matrix_row_echelon_reduce dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state: its own copy of the store, pivots and registers.
  logic signed [31:0] grid [mrer_pkg::MAX_ROWS][mrer_pkg::MAX_COLS];
  logic signed [31:0] piv_val [mrer_pkg::MAX_ROWS];
  int                 piv_col [mrer_pkg::MAX_ROWS];
  bit                 piv_ok [mrer_pkg::MAX_ROWS];
  int                 fill_pos;
  logic [3:0]         rows_reg;
  logic [3:0]         cols_reg;
  logic [15:0]        thresh_reg;

  act_t       pending_acts[$];
  elem_out_t  reduced_elems[$];
  int         errors;
  bit         stimulus_done;
  bit         hold_sink;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic int clamp_size(input logic [3:0] v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic signed [31:0] saturate(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Reduce row r against reference row l, moving r's pivot past the zeroed
  // entry to the first remaining one above the threshold.
  function automatic void eliminate(input int l, input int r, input int nc);
    logic signed [63:0] a, big_a, q, diff, mag;
    logic signed [31:0] v;
    int pc;
    bit seeking;
    a = piv_val[l];
    big_a = piv_val[r];
    pc = piv_col[r];
    seeking = 1;
    grid[r][pc] = 0;
    for (int k = pc + 1; k < nc; k++) begin
      q = (big_a * 64'(grid[l][k])) / a;
      diff = 64'(grid[r][k]) - q;
      v = saturate(diff);
      mag = (v < 0) ? -64'(v) : 64'(v);
      grid[r][k] = v;
      if (seeking && mag > 64'(thresh_reg)) begin
        piv_val[r] = v;
        piv_col[r] = k;
        seeking = 0;
      end
    end
    if (seeking) piv_ok[r] = 0;
  endfunction

  // Accept one element into the predictor; the flagged last one reduces the
  // matrix and queues the whole result in row-major order.
  function automatic void accept_element(input logic [31:0] value, input logic last);
    int nr, nc;
    elem_out_t e;
    nr = clamp_size(rows_reg, mrer_pkg::MAX_ROWS);
    nc = clamp_size(cols_reg, mrer_pkg::MAX_COLS);
    if (fill_pos < nr * nc) begin
      grid[fill_pos / nc][fill_pos % nc] = value;
      fill_pos++;
    end
    if (!last) return;
    for (int r = 0; r < nr; r++) begin
      piv_ok[r] = 0;
      for (int c = 0; c < nc; c++) begin
        if (grid[r][c] != 0) begin
          piv_val[r] = grid[r][c];
          piv_col[r] = c;
          piv_ok[r] = 1;
          break;
        end
      end
    end
    for (int j = 0; j + 1 < nc; j++)
      for (int l = 0; l < nr; l++) begin
        if (!piv_ok[l] || piv_col[l] != j) continue;
        for (int r = 0; r < nr; r++)
          if (r != l && piv_ok[r] && piv_col[r] == j) eliminate(l, r, nc);
      end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        e.value = grid[r][c];
        e.row = r[2:0];
        e.col = c[2:0];
        e.last = (r == nr - 1) && (c == nc - 1);
        reduced_elems.push_back(e);
      end
    fill_pos = 0;
  endfunction

  // Random gap lengths: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] rand_value();
    int p;
    p = $urandom_range(9);
    case (p)
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return $urandom_range(1, 0) ? 32'h00010000 : 32'hffff0000;
      4: return 32'($signed($urandom_range(512)) - 256);
      5, 6: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] data);
    act_t a;
    a = '0;
    a.kind = ACT_DRAIN;
    pending_acts.push_back(a);
    a.kind = ACT_CFG;
    a.index = idx;
    a.cdata = data;
    pending_acts.push_back(a);
  endtask

  task automatic add_elem(input logic [31:0] v, input logic last);
    act_t a;
    a = '0;
    a.kind = ACT_ELEM;
    a.value = v;
    a.last = last;
    pending_acts.push_back(a);
  endtask

  // A whole matrix of the current size. Some rows share leading zeros or
  // repeat so that several rows compete for the same pivot column.
  task automatic add_matrix(input int nr, input int nc);
    logic [31:0] rowbuf [mrer_pkg::MAX_COLS];
    int lead;
    for (int r = 0; r < nr; r++) begin
      lead = $urandom_range(2) == 0 ? $urandom_range(nc - 1) : 0;
      for (int c = 0; c < nc; c++) begin
        if (c < lead) rowbuf[c] = 0;
        else if (r > 0 && $urandom_range(5) == 0) rowbuf[c] = rowbuf[c];
        else rowbuf[c] = rand_value();
      end
      for (int c = 0; c < nc; c++) add_elem(rowbuf[c], (r == nr - 1) && (c == nc - 1));
    end
  endtask

  int cur_rows, cur_cols;

  task automatic set_size(input int nr, input int nc);
    add_cfg(mrer_pkg::REG_ROWS, 16'(nr));
    add_cfg(mrer_pkg::REG_COLS, 16'(nc));
    cur_rows = clamp_size(4'(nr), mrer_pkg::MAX_ROWS);
    cur_cols = clamp_size(4'(nc), mrer_pkg::MAX_COLS);
  endtask

  initial begin
    int total, n;
    rst = 1'b1;
    errors = 0;
    fill_pos = 0;
    rows_reg = 4'd8;
    cols_reg = 4'd8;
    thresh_reg = 16'd0;
    total = 0;

    // Directed part: extremes, saturation, a zero row and pivot ties on small
    // matrices, then a full 8x8 with the threshold register at its maximum.
    set_size(2, 2);
    add_elem(32'h7fffffff, 0); add_elem(32'h80000000, 0);
    add_elem(32'h80000000, 0); add_elem(32'h7fffffff, 1);
    add_elem(32'h00000001, 0); add_elem(32'h80000000, 0);
    add_elem(32'hffffffff, 0); add_elem(32'h7fffffff, 1);
    set_size(3, 3);
    add_elem(0, 0); add_elem(0, 0); add_elem(0, 0);
    add_elem(0, 0); add_elem(32'h00010000, 0); add_elem(32'h00020000, 0);
    add_elem(0, 0); add_elem(32'h00020000, 0); add_elem(32'h00040001, 1);
    // Too many elements: extras are dropped, the last one still reduces.
    set_size(1, 2);
    add_elem(32'h00030000, 0); add_elem(32'h00010000, 0); add_elem(32'h55555555, 1);
    // Out-of-range sizes are clamped.
    set_size(0, 15);
    add_matrix(cur_rows, cur_cols);
    add_cfg(mrer_pkg::REG_THRESHOLD, 16'hffff);
    set_size(8, 8);
    add_matrix(8, 8);
    total = 28 + 64;

    // Random part: mostly well-formed matrices, occasionally short ones that
    // rely on the store keeping earlier contents.
    while (total < 320) begin
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(2);
        add_cfg(mrer_pkg::REG_THRESHOLD,
                n == 0 ? 16'd0 : n == 1 ? 16'hffff : 16'($urandom()));
      end
      if ($urandom_range(2) == 0)
        set_size($urandom_range(9) == 0 ? $urandom_range(15, 9) : $urandom_range(5, 1),
                 $urandom_range(9) == 0 ? 0 : $urandom_range(5, 1));
      if ($urandom_range(7) == 0 && cur_rows * cur_cols > 1) begin
        n = $urandom_range(cur_rows * cur_cols - 1, 1);
        for (int i = 0; i < n; i++) add_elem(rand_value(), i == n - 1);
        total += n;
      end else begin
        add_matrix(cur_rows, cur_cols);
        total += cur_rows * cur_cols;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: walks the queue, inserts random gaps, performs register writes
  // only once the block has drained every expected result.
  int gap_cnt;
  int drain_wait;
  always @(posedge clk) begin
    act_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      gap_cnt <= 0;
      drain_wait <= 0;
      stimulus_done <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accept_element(s_tdata, s_tlast);
        void'(pending_acts.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mrer_pkg::REG_ROWS:      rows_reg = cfg_data[3:0];
          mrer_pkg::REG_COLS:      cols_reg = cfg_data[3:0];
          mrer_pkg::REG_THRESHOLD: thresh_reg = cfg_data;
          default: ;
        endcase
        void'(pending_acts.pop_front());
      end
      if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready)) begin
        // hold the offer until it is taken
      end else if (pending_acts.size() == 0) begin
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (pending_acts[0].kind == ACT_DRAIN) begin
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        if (reduced_elems.size() != 0) drain_wait <= 0;
        else if (drain_wait < 4) drain_wait <= drain_wait + 1;
        else begin
          drain_wait <= 0;
          void'(pending_acts.pop_front());
        end
      end else if (gap_cnt > 0) begin
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else begin
        a = pending_acts[0];
        gap_cnt <= gap_len();
        if (a.kind == ACT_CFG) begin
          s_tvalid <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_index <= a.index;
          cfg_data <= a.cdata;
        end else begin
          cfg_valid <= 1'b0;
          s_tvalid <= 1'b1;
          s_tdata <= a.value;
          s_tlast <= a.last;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off early on while the
  // sender keeps offering so that the block backs up.
  int sink_gap;
  int results_seen;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(3) == 0) sink_gap <= gap_len();
    end
  end

  initial begin
    hold_sink = 1'b0;
    wait (results_seen > 0);
    hold_sink = 1'b1;
    repeat (3000) @(posedge clk);
    hold_sink = 1'b0;
  end

  // Monitor: compare each transfer with the oldest predicted element.
  always @(posedge clk) begin
    elem_out_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (reduced_elems.size() == 0) begin
        report("unexpected transfer", {24'd0, m_tdata}, 64'd0);
      end else begin
        want = reduced_elems.pop_front();
        if (m_tdata[31:0] !== want.value)
          report("value", 64'(m_tdata[31:0]), 64'(want.value));
        if (m_tdata[34:32] !== want.row)
          report("row", 64'(m_tdata[34:32]), 64'(want.row));
        if (m_tdata[37:35] !== want.col)
          report("col", 64'(m_tdata[37:35]), 64'(want.col));
        if (m_tdata[39:38] !== 2'b00) report("fill", 64'(m_tdata[39:38]), 64'd0);
        if (m_tlast !== want.last) report("last", 64'(m_tlast), 64'(want.last));
      end
    end
  end

  // Watchdog on cycles without any accepted transfer, long enough for a
  // full 8x8 reduction and the long receiver hold-off.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL matrix_row_echelon_reduce");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (!(stimulus_done && reduced_elems.size() == 0)) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && reduced_elems.size() == 0) begin
      $display("PASS matrix_row_echelon_reduce");
    end else begin
      $display("FAIL matrix_row_echelon_reduce");
    end
    $finish;
  end

endmodule
